[rtl/jse_pkg.sv]
// ---------------------------------------------------------------------------
// jse_pkg
// shared types and character codes of the json string escaper
// ---------------------------------------------------------------------------
package jse_pkg;

  // characters used by the front, the back or both
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_D      = 8'h64;

  // length of the main piece: up to six literal characters
  localparam int unsigned MAIN_MAX = 6;

  // replacement escape is six characters long, last index 5
  localparam logic [2:0] REP_LAST = 3'd5;

  // queue depth between front and back
  localparam int unsigned Q_DEPTH = 2;

  // one command: everything a single input byte causes, in output order
  typedef struct packed {
    logic                       open;      // opening quote
    logic [2:0]                 rep_a;     // replacements before the main piece
    logic [2:0]                 main_len;  // literal characters in main
    logic [MAIN_MAX-1:0][7:0]   main;      // literal characters
    logic [1:0]                 rep_b;     // replacements after the main piece
    logic                       close;     // closing quote
  } jse_cmd_t;

  // queue head as seen by the back
  typedef struct packed {
    logic     valid;
    jse_cmd_t cmd;
  } jse_head_t;

endpackage

[rtl/json_string_escaper_utf8_validating.sv]
// ---------------------------------------------------------------------------
// json_string_escaper_utf8_validating
// streaming json string escaper with utf-8 validation, top level
// ---------------------------------------------------------------------------
// Bytes of a string enter one per transfer, the last one flagged by
// in_end_of_string; the block sends the quoted, escaped JSON text one
// character per output transfer, final_char marking the closing quote.
// Quote, backslash and BS/FF/LF/CR/TAB get two-character escapes, other
// control bytes become \u00xx, ASCII passes unchanged, and a multi-byte UTF-8
// sequence is held until its last byte: well formed it passes raw, otherwise
// each of its bytes becomes \ufffd (as do stray bytes and bytes still held at
// the end of the string). The input takes one byte per cycle as long as the
// output keeps up; the output moves one character per cycle while out_ready
// is high, so a long expansion holds the output for each of its characters,
// and the two-entry command queue between the classifying front and the
// emitting back is what then holds the input off. A byte that only extends
// a held sequence pushes no command and takes no output character. An
// accepted byte's command is registered in the queue, and its characters
// then leave through the back's output register. No start-up pass after reset.
// ---------------------------------------------------------------------------
module json_string_escaper_utf8_validating
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_in,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_char,
  output logic       out_final_char
);

  // command from the front and queue status
  jse_cmd_t  cmd;
  logic      push;
  logic      q_full;
  jse_head_t head;
  logic      pop;

  // front: utf-8 tracking and classification of each transfer
  jse_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_in       (in_data_in),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .push             (push),
    .cmd              (cmd)
  );

  // decouples the two sides so each can stall on its own
  jse_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  // back: expands the head command, output register included
  jse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_char   (out_out_char),
    .out_final_char (out_final_char)
  );

endmodule

[rtl/jse_front.sv]
// ---------------------------------------------------------------------------
// jse_front
// takes bytes, tracks utf-8 sequence state and turns each byte into a command
// ---------------------------------------------------------------------------
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_in,
  input  logic       in_end_of_string,
  input  logic       q_full,
  output logic       push,
  output jse_cmd_t   cmd
);

  localparam logic [7:0] MASK_CONT = 8'hc0;
  localparam logic [7:0] CODE_CONT = 8'h80;
  localparam logic [7:0] MASK_L2   = 8'he0;
  localparam logic [7:0] CODE_L2   = 8'hc0;
  localparam logic [7:0] MASK_L3   = 8'hf0;
  localparam logic [7:0] CODE_L3   = 8'he0;
  localparam logic [7:0] MASK_L4   = 8'hf8;
  localparam logic [7:0] CODE_L4   = 8'hf0;
  localparam logic [20:0] MIN_L2   = 21'h80;
  localparam logic [20:0] MIN_L3   = 21'h800;
  localparam logic [20:0] MIN_L4   = 21'h10000;
  localparam logic [20:0] MAX_CP   = 21'h10ffff;
  localparam logic [20:0] SUR_LO   = 21'hd800;
  localparam logic [20:0] SUR_HI   = 21'hdfff;
  localparam logic [2:0]  LEN_2    = 3'd2;
  localparam logic [2:0]  LEN_3    = 3'd3;
  localparam logic [2:0]  LEN_4    = 3'd4;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) c = CH_ZERO + {4'd0, v};
    else c = 8'h61 + {4'd0, v} - 8'd10;
    return c;
  endfunction

  logic            inside_r, inside_nxt;
  logic [2:0][7:0] pend_r, pend_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [2:0]      elen_r, elen_nxt;

  logic [7:0]      b;
  logic            is_cont, do_fresh, seq_ok, accept;
  logic [3:0][7:0] seq;
  logic [20:0]     cp;
  logic [7:0]      esc;
  logic [2:0]      lead_len;

  assign b        = in_data_in;
  assign is_cont  = (b & MASK_CONT) == CODE_CONT;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // held sequence with the new byte in its final place
  always_comb begin
    seq = {8'd0, pend_r[2], pend_r[1], pend_r[0]};
    case (elen_r)
      LEN_2:   seq[1] = b;
      LEN_3:   seq[2] = b;
      LEN_4:   seq[3] = b;
      default: seq[1] = b;
    endcase
  end

  // code point and validity of a completed sequence
  always_comb begin
    case (elen_r)
      LEN_2: begin
        cp     = {10'd0, seq[0][4:0], seq[1][5:0]};
        seq_ok = cp >= MIN_L2;
      end
      LEN_3: begin
        cp     = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
        seq_ok = (cp >= MIN_L3) && !((cp >= SUR_LO) && (cp <= SUR_HI));
      end
      LEN_4: begin
        cp     = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
        seq_ok = (cp >= MIN_L4) && (cp <= MAX_CP);
      end
      default: begin
        cp     = '0;
        seq_ok = 1'b0;
      end
    endcase
  end

  // short escapes
  always_comb begin
    case (b)
      8'h22:   esc = CH_QUOTE;
      8'h5c:   esc = CH_BSLASH;
      8'h08:   esc = 8'h62;
      8'h0c:   esc = CH_F;
      8'h0a:   esc = 8'h6e;
      8'h0d:   esc = 8'h72;
      8'h09:   esc = 8'h74;
      default: esc = 8'h00;
    endcase
  end

  always_comb begin
    if ((b & MASK_L2) == CODE_L2) lead_len = LEN_2;
    else if ((b & MASK_L3) == CODE_L3) lead_len = LEN_3;
    else if ((b & MASK_L4) == CODE_L4) lead_len = LEN_4;
    else lead_len = 3'd0;
  end

  always_comb begin
    cmd        = '0;
    cmd.open   = !inside_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    elen_nxt   = elen_r;
    do_fresh   = 1'b1;
    inside_nxt = !in_end_of_string;

    if (pcnt_r != 2'd0) begin
      if (is_cont) begin
        do_fresh = 1'b0;
        if (({1'b0, pcnt_r} + 3'd1) >= elen_r) begin
          // sequence complete
          if (seq_ok) begin
            cmd.main_len = elen_r;
            cmd.main[3:0] = seq;
          end else begin
            cmd.rep_a = elen_r;
          end
          pcnt_nxt = 2'd0;
          elen_nxt = 3'd0;
        end else begin
          if (pcnt_r == 2'd1) pend_nxt[1] = b;
          else pend_nxt[2] = b;
          pcnt_nxt = pcnt_r + 2'd1;
        end
      end else begin
        // broken sequence: each held byte replaced, new byte examined afresh
        cmd.rep_a = {1'b0, pcnt_r};
        pcnt_nxt  = 2'd0;
        elen_nxt  = 3'd0;
      end
    end

    if (do_fresh) begin
      if (esc != 8'h00) begin
        cmd.main_len = 3'd2;
        cmd.main[0]  = CH_BSLASH;
        cmd.main[1]  = esc;
      end else if (b < 8'h20) begin
        cmd.main_len = 3'd6;
        cmd.main[0]  = CH_BSLASH;
        cmd.main[1]  = CH_U;
        cmd.main[2]  = CH_ZERO;
        cmd.main[3]  = CH_ZERO;
        cmd.main[4]  = hex_char(b[7:4]);
        cmd.main[5]  = hex_char(b[3:0]);
      end else if (b < 8'h80) begin
        cmd.main_len = 3'd1;
        cmd.main[0]  = b;
      end else if (lead_len == 3'd0) begin
        // stray byte
        cmd.rep_a = cmd.rep_a + 3'd1;
      end else begin
        pend_nxt[0] = b;
        pcnt_nxt    = 2'd1;
        elen_nxt    = lead_len;
      end
    end

    if (in_end_of_string) begin
      cmd.rep_b = pcnt_nxt;
      cmd.close = 1'b1;
      pcnt_nxt  = 2'd0;
      elen_nxt  = 3'd0;
    end
  end

  // commands that produce nothing are not queued
  assign push = accept && (cmd.open || (cmd.rep_a != 3'd0) || (cmd.main_len != 3'd0) ||
                           (cmd.rep_b != 2'd0) || cmd.close);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      pcnt_r   <= 2'd0;
      elen_r   <= 3'd0;
    end else if (accept) begin
      inside_r <= inside_nxt;
      pcnt_r   <= pcnt_nxt;
      elen_r   <= elen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pend_shorter: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != 2'd0) |-> ({1'b0, pcnt_r} < elen_r))
    else $error("held byte count not below sequence length");
  a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r == 2'd0) |-> (elen_r == 3'd0))
    else $error("sequence length set with nothing held");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_string) |=> (!inside_r && (pcnt_r == 2'd0)))
    else $error("string state not cleared after last byte");
`endif

endmodule

[rtl/jse_queue.sv]
// ---------------------------------------------------------------------------
// jse_queue
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module jse_queue
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  jse_cmd_t  push_cmd,
  input  logic      pop,
  output logic      full,
  output jse_head_t head
);

  jse_cmd_t   q_r [Q_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'(Q_DEPTH);
  assign head.valid = cnt_r != 2'd0;
  assign head.cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("command popped from empty queue");
`endif

endmodule

[rtl/jse_back.sv]
// ---------------------------------------------------------------------------
// jse_back
// walks the head command into the output register, one char per unstalled cycle
// ---------------------------------------------------------------------------
module jse_back
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  jse_head_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_out_char,
  output logic      out_final_char
);

  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_REPA  = 3'd1;
  localparam logic [2:0] PH_MAIN  = 3'd2;
  localparam logic [2:0] PH_REPB  = 3'd3;
  localparam logic [2:0] PH_CLOSE = 3'd4;

  function automatic logic [7:0] rep_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = CH_BSLASH;
      3'd1:    c = CH_U;
      3'd2:    c = CH_F;
      3'd3:    c = CH_F;
      3'd4:    c = CH_F;
      default: c = CH_D;
    endcase
    return c;
  endfunction

  jse_cmd_t   cmd;
  logic [2:0] ph_r, ph_nxt, cnt_r, cnt_nxt, sub_r, sub_nxt, eff, cnt_inc;
  logic       done, later, last, fire;
  logic [7:0] ch;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_final_r;

  assign cmd     = head.cmd;
  assign cnt_inc = cnt_r + 3'd1;

  // first phase at or after the current one that has something to emit
  always_comb begin
    if (cmd.open && (ph_r == PH_OPEN)) eff = PH_OPEN;
    else if ((cmd.rep_a != 3'd0) && (ph_r <= PH_REPA)) eff = PH_REPA;
    else if ((cmd.main_len != 3'd0) && (ph_r <= PH_MAIN)) eff = PH_MAIN;
    else if ((cmd.rep_b != 2'd0) && (ph_r <= PH_REPB)) eff = PH_REPB;
    else eff = PH_CLOSE;
  end

  always_comb begin
    case (eff)
      PH_OPEN: begin
        ch   = CH_QUOTE;
        done = 1'b1;
      end
      PH_REPA: begin
        ch   = rep_char(sub_r);
        done = (sub_r == REP_LAST) && (cnt_inc == cmd.rep_a);
      end
      PH_MAIN: begin
        ch   = cmd.main[cnt_r];
        done = cnt_inc == cmd.main_len;
      end
      PH_REPB: begin
        ch   = rep_char(sub_r);
        done = (sub_r == REP_LAST) && (cnt_inc == {1'b0, cmd.rep_b});
      end
      default: begin
        ch   = CH_QUOTE;
        done = 1'b1;
      end
    endcase
  end

  assign later = ((eff < PH_REPA) && (cmd.rep_a != 3'd0)) ||
                 ((eff < PH_MAIN) && (cmd.main_len != 3'd0)) ||
                 ((eff < PH_REPB) && (cmd.rep_b != 2'd0)) ||
                 ((eff < PH_CLOSE) && cmd.close);
  assign last  = done && !later;
  assign fire  = head.valid && (!out_valid_r || out_ready);
  assign pop   = fire && last;

  always_comb begin
    ph_nxt  = eff;
    cnt_nxt = cnt_r;
    sub_nxt = sub_r;
    if (last) begin
      ph_nxt  = PH_OPEN;
      cnt_nxt = 3'd0;
      sub_nxt = 3'd0;
    end else if (done) begin
      ph_nxt  = eff + 3'd1;
      cnt_nxt = 3'd0;
      sub_nxt = 3'd0;
    end else if (eff == PH_MAIN) begin
      cnt_nxt = cnt_inc;
    end else if (sub_r == REP_LAST) begin
      sub_nxt = 3'd0;
      cnt_nxt = cnt_inc;
    end else begin
      sub_nxt = sub_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_OPEN;
      cnt_r       <= 3'd0;
      sub_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        ph_r  <= ph_nxt;
        cnt_r <= cnt_nxt;
        sub_r <= sub_nxt;
      end
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char_r  <= ch;
      out_final_r <= eff == PH_CLOSE;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_char   = out_char_r;
  assign out_final_char = out_final_r;

`ifndef SYNTHESIS
  a_final_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_final_r) |-> (out_char_r == CH_QUOTE))
    else $error("final character is not a closing quote");
`endif

endmodule
